[sv/one_shot_alarm_table_defines.svh]
// ----------------------------------------------------------------------------
// one_shot_alarm_table assertion macros
// shared concurrent assertion forms for the alarm table checker
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_ALARM_TABLE_DEFINES_SVH
`define ONE_SHOT_ALARM_TABLE_DEFINES_SVH

// same-cycle implication
`define OAT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/oat_pkg.sv]
// ----------------------------------------------------------------------------
// oat_pkg
// types and constants shared by the alarm table controller and datapath
// ----------------------------------------------------------------------------
package oat_pkg;

  localparam int OWNER_W     = 4;
  localparam int DELAY_W     = 32;
  localparam int TICK_W      = 32;
  localparam int CFG_W       = 10;
  localparam int KIND_W      = 2;
  localparam int MAX_RESULTS = 16;
  localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int DIV_STEPS   = DELAY_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam logic [CFG_W-1:0] MS_PER_TICK_RESET = CFG_W'(10);

  typedef enum logic [KIND_W-1:0] {
    KIND_OK    = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_FIRED = 2'd2
  } kind_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_WRITE = 7'b0010000,
    ST_RESP  = 7'b0100000,
    ST_FLUSH = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic div_step;
    logic write;
    logic emit_set;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic issue_last;
    logic is_set;
    logic div_last;
  } status_t;

endpackage

[sv/oat_ram.sv]
// ----------------------------------------------------------------------------
// oat_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module oat_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/oat_ctrl.sv]
// ----------------------------------------------------------------------------
// oat_ctrl
// sequencer for table scan, delay division, slot write and result issue
// ----------------------------------------------------------------------------
module oat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output oat_pkg::cmd_t    cmd,
  input  oat_pkg::status_t status
);

  oat_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      oat_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = oat_pkg::ST_SCAN;
        end
      end
      oat_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.issue_last) begin
          state_next = oat_pkg::ST_DRAIN;
        end
      end
      oat_pkg::ST_DRAIN: begin
        state_next = status.is_set ? oat_pkg::ST_DIV : oat_pkg::ST_FLUSH;
      end
      oat_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = oat_pkg::ST_WRITE;
        end
      end
      oat_pkg::ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = oat_pkg::ST_RESP;
      end
      oat_pkg::ST_RESP: begin
        cmd.emit_set = 1'b1;
        state_next   = oat_pkg::ST_IDLE;
      end
      oat_pkg::ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = oat_pkg::ST_IDLE;
      end
      default: begin
        state_next = oat_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != oat_pkg::ST_IDLE);

endmodule

[sv/oat_dp.sv]
// ----------------------------------------------------------------------------
// oat_dp
// alarm table datapath: slot store, scan pipeline, divider and result register
// ----------------------------------------------------------------------------
module oat_dp #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  oat_pkg::cmd_t                cmd,
  output oat_pkg::status_t             status,
  input  logic                         req_type,
  input  logic [oat_pkg::OWNER_W-1:0]  owner,
  input  logic [oat_pkg::DELAY_W-1:0]  delay_ms,
  input  logic                         cfg_write,
  input  logic [oat_pkg::CFG_W-1:0]    cfg_data,
  output logic                         result_strobe,
  output logic [oat_pkg::KIND_W-1:0]   result_kind,
  output logic [oat_pkg::OWNER_W-1:0]  fired_owner,
  output logic                         last
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int ENT_W = oat_pkg::OWNER_W + oat_pkg::TICK_W;

  logic [oat_pkg::CFG_W-1:0]      ms_per_tick;
  logic [oat_pkg::TICK_W-1:0]     tick_count;
  logic [TABLE_ENTRIES-1:0]       slot_valid;
  logic                           set_r;
  logic [oat_pkg::OWNER_W-1:0]    owner_r;
  logic                           delay_nz;
  logic [IDX_W-1:0]               scan_idx;
  logic [IDX_W-1:0]               rd_idx;
  logic                           rd_live;
  logic [ENT_W-1:0]               rd_data;
  logic [oat_pkg::OWNER_W-1:0]    rd_owner;
  logic [oat_pkg::TICK_W-1:0]     rd_fire;
  logic                           cancel_found;
  logic                           free_found;
  logic [IDX_W-1:0]               free_idx;
  logic                           pend_valid;
  logic [oat_pkg::OWNER_W-1:0]    pend_owner;
  logic [oat_pkg::FIRE_CNT_W-1:0] fire_cnt;
  logic [oat_pkg::DELAY_W-1:0]    quot;
  logic [oat_pkg::CFG_W-1:0]      rem;
  logic [oat_pkg::DIV_CNT_W-1:0]  div_cnt;
  logic [oat_pkg::CFG_W:0]        rem_sh;
  logic [oat_pkg::CFG_W:0]        rem_diff;
  logic                           q_bit;
  logic                           slot_match;
  logic                           slot_free;
  logic                           slot_due;
  logic                           ram_we;
  logic [ENT_W-1:0]               ram_wdata;

  assign rd_owner = rd_data[ENT_W-1 -: oat_pkg::OWNER_W];
  assign rd_fire  = rd_data[oat_pkg::TICK_W-1:0];

  assign rem_sh   = {rem, quot[oat_pkg::DELAY_W-1]};
  assign rem_diff = rem_sh - {1'b0, ms_per_tick};
  assign q_bit    = (rem_sh >= {1'b0, ms_per_tick});

  assign slot_match = rd_live && set_r && slot_valid[rd_idx] && (rd_owner == owner_r)
                      && !cancel_found;
  assign slot_free  = rd_live && set_r && (!slot_valid[rd_idx] || slot_match) && !free_found;
  assign slot_due   = rd_live && !set_r && slot_valid[rd_idx] && (tick_count >= rd_fire)
                      && (fire_cnt < oat_pkg::FIRE_CNT_W'(oat_pkg::MAX_RESULTS));

  assign ram_we    = cmd.write && delay_nz && free_found;
  assign ram_wdata = {owner_r, tick_count + quot};

  oat_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (rd_data)
  );

  assign status.issue_last = (scan_idx == IDX_W'(TABLE_ENTRIES - 1));
  assign status.is_set     = set_r;
  assign status.div_last   = (div_cnt == oat_pkg::DIV_CNT_W'(oat_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_per_tick   <= oat_pkg::MS_PER_TICK_RESET;
      tick_count    <= '0;
      slot_valid    <= '0;
      rd_live       <= 1'b0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      rd_live       <= cmd.scan;
      if (cfg_write) begin
        ms_per_tick <= cfg_data;
      end
      if (cmd.load) begin
        pend_valid <= 1'b0;
        if (!req_type) begin
          tick_count <= tick_count + oat_pkg::TICK_W'(1);
        end
      end
      if (slot_match) begin
        slot_valid[rd_idx] <= 1'b0;
      end
      if (slot_due) begin
        slot_valid[rd_idx] <= 1'b0;
        pend_valid         <= 1'b1;
        if (pend_valid) begin
          result_strobe <= 1'b1;
        end
      end
      if (ram_we) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
        if (pend_valid) begin
          result_strobe <= 1'b1;
        end
      end
      if (cmd.emit_set) begin
        result_strobe <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (cmd.load) begin
      set_r        <= req_type;
      owner_r      <= owner;
      delay_nz     <= (delay_ms != '0);
      scan_idx     <= '0;
      cancel_found <= 1'b0;
      free_found   <= 1'b0;
      fire_cnt     <= '0;
      quot         <= delay_ms;
      rem          <= '0;
      div_cnt      <= '0;
    end
    if (cmd.scan) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (slot_match) begin
      cancel_found <= 1'b1;
    end
    if (slot_free) begin
      free_found <= 1'b1;
      free_idx   <= rd_idx;
    end
    if (cmd.div_step) begin
      quot    <= {quot[oat_pkg::DELAY_W-2:0], q_bit};
      rem     <= q_bit ? rem_diff[oat_pkg::CFG_W-1:0] : rem_sh[oat_pkg::CFG_W-1:0];
      div_cnt <= div_cnt + oat_pkg::DIV_CNT_W'(1);
    end
    if (slot_due) begin
      fire_cnt   <= fire_cnt + oat_pkg::FIRE_CNT_W'(1);
      pend_owner <= rd_owner;
      if (pend_valid) begin
        result_kind <= oat_pkg::KIND_FIRED;
        fired_owner <= pend_owner;
        last        <= 1'b0;
      end
    end
    if (cmd.flush) begin
      result_kind <= oat_pkg::KIND_FIRED;
      fired_owner <= pend_owner;
      last        <= 1'b1;
    end
    if (cmd.emit_set) begin
      result_kind <= (delay_nz && !free_found) ? oat_pkg::KIND_FULL : oat_pkg::KIND_OK;
      fired_owner <= '0;
      last        <= 1'b1;
    end
  end

endmodule

[sv/one_shot_alarm_table.sv]
// ----------------------------------------------------------------------------
// one_shot_alarm_table
// table of one-shot alarms, one per owner, beside a request-driven tick count
// ----------------------------------------------------------------------------
// One request at a time: start is taken while busy is low. A tick request
// holds busy through a walk of the slot table through the single read port
// of the table RAM one slot per cycle; fired alarms come out in slot order,
// the final one marked with last. A set request holds busy through the same
// slot walk, then a 32-step serial divider for the delay, a slot write and a
// single ok or full result. Results are shown for one cycle on result_strobe
// and cannot be held off. The slot valid bits are flip-flops, so the table is
// usable straight out of reset.
module one_shot_alarm_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type,
  input  logic [oat_pkg::OWNER_W-1:0]  owner,
  input  logic [oat_pkg::DELAY_W-1:0]  delay_ms,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [oat_pkg::CFG_W-1:0]    cfg_data,
  output logic                         result_strobe,
  output logic [oat_pkg::KIND_W-1:0]   result_kind,
  output logic [oat_pkg::OWNER_W-1:0]  fired_owner,
  output logic                         last
);

  oat_pkg::cmd_t    cmd;
  oat_pkg::status_t status;

  assign cfg_ready = 1'b1;

  oat_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  oat_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .req_type      (req_type),
    .owner         (owner),
    .delay_ms      (delay_ms),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .result_kind   (result_kind),
    .fired_owner   (fired_owner),
    .last          (last)
  );

endmodule

[sv/oat_checker.sv]
// ----------------------------------------------------------------------------
// oat_checker
// port-level checks for the alarm table, bound to the top level
// ----------------------------------------------------------------------------
`include "one_shot_alarm_table_defines.svh"

module oat_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        result_strobe,
  input logic [oat_pkg::KIND_W-1:0]  result_kind,
  input logic [oat_pkg::OWNER_W-1:0] fired_owner,
  input logic                        last
);

  `OAT_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted transaction not busy")
  `OAT_ASSERT_NOW(a_set_last, clk, rst, result_strobe && (result_kind != oat_pkg::KIND_FIRED), last, "set result without last")
  `OAT_ASSERT_NOW(a_set_owner, clk, rst, result_strobe && (result_kind != oat_pkg::KIND_FIRED), fired_owner == '0, "set result with owner")
  `OAT_ASSERT_NOW(a_kind_legal, clk, rst, result_strobe, (result_kind == oat_pkg::KIND_OK) || (result_kind == oat_pkg::KIND_FULL) || (result_kind == oat_pkg::KIND_FIRED), "bad result kind")

endmodule

bind one_shot_alarm_table oat_checker u_oat_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .result_kind   (result_kind),
  .fired_owner   (fired_owner),
  .last          (last)
);
